FILE: hdl/est_pkg.sv
// Shared types, constants and helper functions for the encoder synchronized spin turn.
`timescale 1ns / 1ps
package est_pkg;

   localparam int COUNT_BITS_DEF    = 16;
   localparam int DEG_BITS          = 16;
   localparam int POWER_BITS        = 8;
   localparam int PPH_BITS          = 8;
   localparam int DRIVE_BITS        = 9;
   localparam int PROD_BITS         = DEG_BITS + PPH_BITS;
   localparam int QUO_BITS          = 16;
   localparam int REQ_DATA_BITS     = 32;
   localparam int RSP_DATA_BITS     = 24;

   localparam logic [PPH_BITS-1:0] PPH_RESET = 8'd22;
   localparam int DEG_PER_HALF_TURN = 180;

   // prod / 180 = (prod >> 2) / 45, done as multiply by ceil(2^27 / 45) and shift
   localparam int RECIP_IN_BITS = PROD_BITS - 2;
   localparam int RECIP_BITS    = 22;
   localparam int RECIP_SHIFT   = 27;
   localparam logic [RECIP_BITS-1:0] RECIP_MULT = 22'd2982617;

   localparam logic [PROD_BITS-1:0] PROD_ONE_TURN_STEP = PROD_BITS'(DEG_PER_HALF_TURN);
   localparam logic [PROD_BITS-1:0] PROD_TWO_TURN_STEP = PROD_BITS'(2 * DEG_PER_HALF_TURN);

   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_START  = 1'b1;

   typedef struct packed {
      logic                  action;
      logic                  turn_right;
      logic [PROD_BITS-1:0]  prod;
      logic [POWER_BITS-1:0] power;
      logic                  left_level;
      logic                  right_level;
   } est_item_type;

   function automatic logic [DRIVE_BITS-1:0] drive_code(input logic [POWER_BITS-1:0] power,
                                                        input logic negative);
      logic [DRIVE_BITS-1:0] mag;
      mag = {1'b0, power};
      drive_code = negative ? (~mag + DRIVE_BITS'(1)) : mag;
   endfunction

endpackage

FILE: hdl/est_input_stage.sv
// Input register: angle magnitude times half-turn pulses, direction and levels.
`timescale 1ns / 1ps
module est_input_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [est_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tuser,
   input  logic [est_pkg::PPH_BITS-1:0]       pph,
   input  logic                               core_ready,
   output logic                               item_valid,
   output est_pkg::est_item_type              item
);

   logic                                 valid_ff;
   logic                                 valid_in;
   est_pkg::est_item_type                item_ff;
   est_pkg::est_item_type                item_in;
   logic [est_pkg::DEG_BITS-1:0]         deg;
   logic [est_pkg::DEG_BITS-1:0]         mag;
   logic                                 neg;
   logic                                 take;
   logic                                 fire;

   assign req_tready = !valid_ff || core_ready;
   assign fire       = req_tvalid && req_tready;
   assign take       = valid_ff && core_ready;
   assign deg        = req_tdata[est_pkg::DEG_BITS-1:0];
   assign neg        = deg[est_pkg::DEG_BITS-1];
   assign mag        = neg ? (~deg + est_pkg::DEG_BITS'(1)) : deg;

   always_comb begin
      item_in.action      = req_tuser;
      item_in.turn_right  = !neg && (deg != '0);
      item_in.prod        = {{est_pkg::PPH_BITS{1'b0}}, mag} *
                            {{est_pkg::DEG_BITS{1'b0}}, pph};
      item_in.power       = req_tdata[est_pkg::DEG_BITS +: est_pkg::POWER_BITS];
      item_in.left_level  = req_tdata[est_pkg::DEG_BITS + est_pkg::POWER_BITS];
      item_in.right_level = req_tdata[est_pkg::DEG_BITS + est_pkg::POWER_BITS + 1];
      if (fire) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hdl/est_target_div.sv
// Target pulse count: held product divided by 180, saturated to the counter range.
`timescale 1ns / 1ps
module est_target_div #(
   parameter int COUNT_BITS = est_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [est_pkg::PROD_BITS-1:0]   prod,
   output logic [COUNT_BITS-1:0]           target
);

   localparam int TW = (COUNT_BITS > est_pkg::QUO_BITS) ? COUNT_BITS : est_pkg::QUO_BITS;
   localparam int MW = est_pkg::RECIP_IN_BITS + est_pkg::RECIP_BITS;

   logic [est_pkg::RECIP_IN_BITS-1:0] quarter;
   logic [MW-1:0]                     full;
   logic [est_pkg::QUO_BITS-1:0]      quo;
   logic [TW-1:0]                     quo_w;
   logic [TW-1:0]                     max_w;
   logic [TW-1:0]                     sat_w;
   logic [COUNT_BITS-1:0]             target_ff;
   logic [COUNT_BITS-1:0]             target_in;

   assign quarter = prod[est_pkg::PROD_BITS-1:2];
   assign full    = {{est_pkg::RECIP_BITS{1'b0}}, quarter} *
                    {{est_pkg::RECIP_IN_BITS{1'b0}}, est_pkg::RECIP_MULT};
   assign quo     = full[est_pkg::RECIP_SHIFT +: est_pkg::QUO_BITS];
   assign quo_w   = TW'(quo);
   assign max_w   = TW'({COUNT_BITS{1'b1}});
   assign sat_w   = (quo_w > max_w) ? max_w : quo_w;
   assign target_in = sat_w[COUNT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   assign target = target_ff;

endmodule

FILE: hdl/est_turn_core.sv
// Turn state, wheel counters, stop decisions and the result register.
`timescale 1ns / 1ps
module est_turn_core #(
   parameter int COUNT_BITS = est_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  est_pkg::est_item_type              item,
   output logic                               core_ready,
   input  logic [COUNT_BITS-1:0]              target,
   output logic [est_pkg::PROD_BITS-1:0]      prod_hold,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [est_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] COUNT_TWO = COUNT_BITS'(2);

   logic [COUNT_BITS-1:0]              left_count_ff,  left_count_in;
   logic [COUNT_BITS-1:0]              right_count_ff, right_count_in;
   logic                               prev_left_ff,   prev_left_in;
   logic                               prev_right_ff,  prev_right_in;
   logic                               turn_right_ff,  turn_right_in;
   logic                               busy_ff,        busy_in;
   logic [est_pkg::POWER_BITS-1:0]     power_ff,       power_in;
   logic [est_pkg::PROD_BITS-1:0]      prod_ff,        prod_in;
   logic                               tgt_one_ff,     tgt_one_in;
   logic                               pending_ff,     pending_in;
   logic                               out_valid_ff,   out_valid_in;
   logic [est_pkg::DRIVE_BITS-1:0]     left_drive_ff,  left_drive_in;
   logic [est_pkg::DRIVE_BITS-1:0]     right_drive_ff, right_drive_in;
   logic                               turning_ff,     turning_in;
   logic                               finished_ff,    finished_in;
   logic                               advance;
   logic                               fire;
   logic [COUNT_BITS-1:0]              eff_target;

   assign advance    = !out_valid_ff || rsp_tready;
   assign core_ready = advance;
   assign fire       = item_valid && advance;
   assign eff_target = pending_ff ? (tgt_one_ff ? COUNT_ONE : COUNT_TWO) : target;

   always_comb begin
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      prev_left_in   = prev_left_ff;
      prev_right_in  = prev_right_ff;
      turn_right_in  = turn_right_ff;
      busy_in        = busy_ff;
      power_in       = power_ff;
      prod_in        = prod_ff;
      tgt_one_in     = tgt_one_ff;
      pending_in     = 1'b0;
      left_drive_in  = '0;
      right_drive_in = '0;
      finished_in    = 1'b0;
      out_valid_in   = fire ? 1'b1 : (advance ? 1'b0 : out_valid_ff);
      if (fire) begin
         prev_left_in  = item.left_level;
         prev_right_in = item.right_level;
         if (item.action == est_pkg::ACT_START) begin
            left_count_in  = '0;
            right_count_in = '0;
            turn_right_in  = item.turn_right;
            power_in       = item.power;
            prod_in        = item.prod;
            tgt_one_in     = item.prod < est_pkg::PROD_TWO_TURN_STEP;
            pending_in     = 1'b1;
            if (item.prod < est_pkg::PROD_ONE_TURN_STEP) begin
               busy_in     = 1'b0;
               finished_in = 1'b1;
            end else begin
               busy_in        = 1'b1;
               left_drive_in  = est_pkg::drive_code(item.power, !item.turn_right);
               right_drive_in = est_pkg::drive_code(item.power, item.turn_right);
            end
         end else if (busy_ff) begin
            if (item.left_level != prev_left_ff && left_count_ff != COUNT_MAX) begin
               left_count_in = left_count_ff + COUNT_ONE;
            end
            if (item.right_level != prev_right_ff && right_count_ff != COUNT_MAX) begin
               right_count_in = right_count_ff + COUNT_ONE;
            end
            if (left_count_in >= eff_target && right_count_in >= eff_target) begin
               busy_in     = 1'b0;
               finished_in = 1'b1;
            end else begin
               if (!(left_count_in == eff_target || left_count_in > right_count_in)) begin
                  left_drive_in = est_pkg::drive_code(power_ff, !turn_right_ff);
               end
               if (!(right_count_in == eff_target || right_count_in > left_count_in)) begin
                  right_drive_in = est_pkg::drive_code(power_ff, turn_right_ff);
               end
            end
         end
      end
      turning_in = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_count_ff  <= '0;
         right_count_ff <= '0;
         prev_left_ff   <= 1'b0;
         prev_right_ff  <= 1'b0;
         turn_right_ff  <= 1'b0;
         busy_ff        <= 1'b0;
         power_ff       <= '0;
         prod_ff        <= '0;
         tgt_one_ff     <= 1'b0;
         pending_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
         prev_left_ff   <= prev_left_in;
         prev_right_ff  <= prev_right_in;
         turn_right_ff  <= turn_right_in;
         busy_ff        <= busy_in;
         power_ff       <= power_in;
         prod_ff        <= prod_in;
         tgt_one_ff     <= tgt_one_in;
         pending_ff     <= pending_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         left_drive_ff  <= left_drive_in;
         right_drive_ff <= right_drive_in;
         turning_ff     <= turning_in;
         finished_ff    <= finished_in;
      end
   end

   assign prod_hold  = prod_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(est_pkg::RSP_DATA_BITS - 2 * est_pkg::DRIVE_BITS - 2){1'b0}},
                        finished_ff, turning_ff, right_drive_ff, left_drive_ff};

endmodule

FILE: hdl/encoder_synchronized_spin_turn.sv
// Top level of the encoder synchronized spin turn controller.
//
//   channel   dir   handshake                 payload
//   req       in    req_tvalid / req_tready   req_tdata, req_tuser
//   rsp       out   rsp_tvalid / rsp_tready   rsp_tdata
//   csr       in    csr_wr_en                 csr_wr_data
//
// One beat in per cycle unless rsp stalls; one result per beat, via input and result registers.
// The target divide runs in a register stage behind the held product; the first sample
// after a start is decided from two small compares, so no beat waits on it.
// Reset is synchronous; it clears the turn state and loads 22 into the half-turn register.
// A stalled result holds in the result register while the input register takes one more beat.
`timescale 1ns / 1ps
module encoder_synchronized_spin_turn #(
   parameter int COUNT_BITS = est_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] degrees, [23:16] turn_power, [24] left_encoder, [25] right_encoder
   input  logic [est_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // [0] action
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [8:0] left_drive, [17:9] right_drive, [18] turning, [19] finished
   output logic [est_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [est_pkg::PPH_BITS-1:0]       csr_wr_data
);

   logic [est_pkg::PPH_BITS-1:0]   pph_ff;
   logic [est_pkg::PPH_BITS-1:0]   pph_in;
   logic                           core_ready;
   logic                           item_valid;
   est_pkg::est_item_type          item;
   logic [COUNT_BITS-1:0]          target;
   logic [est_pkg::PROD_BITS-1:0]  prod_hold;

   assign pph_in = csr_wr_en ? csr_wr_data : pph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pph_ff <= est_pkg::PPH_RESET;
      end else begin
         pph_ff <= pph_in;
      end
   end

   est_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pph        (pph_ff),
      .core_ready (core_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   est_target_div #(
      .COUNT_BITS (COUNT_BITS)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .prod   (prod_hold),
      .target (target)
   );

   est_turn_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .core_ready (core_ready),
      .target     (target),
      .prod_hold  (prod_hold),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: hdl/est_checker.sv
// Port-level checks for the spin turn controller, bound to the top level.
`timescale 1ns / 1ps
module est_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [est_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   logic [est_pkg::DRIVE_BITS-1:0] left_drive;
   logic [est_pkg::DRIVE_BITS-1:0] right_drive;
   logic                           turning;
   logic                           finished;

   assign left_drive  = rsp_tdata[est_pkg::DRIVE_BITS-1:0];
   assign right_drive = rsp_tdata[est_pkg::DRIVE_BITS +: est_pkg::DRIVE_BITS];
   assign turning     = rsp_tdata[2 * est_pkg::DRIVE_BITS];
   assign finished    = rsp_tdata[2 * est_pkg::DRIVE_BITS + 1];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_fin_not_turning: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && finished |-> !turning && left_drive == '0 && right_drive == '0)
      else $error("finished beat still turning or driving");

   a_idle_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !turning |-> left_drive == '0 && right_drive == '0)
      else $error("drive active while no turn in progress");

endmodule

bind encoder_synchronized_spin_turn est_checker u_est_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/encoder_synchronized_spin_turn_test.sv
// Self-checking testbench for the encoder synchronized spin turn, with random stream stalls.
`timescale 1ns / 1ps
module encoder_synchronized_spin_turn_test;

   localparam int CNT_BITS = est_pkg::COUNT_BITS_DEF;
   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
   localparam int STALL_LIMIT = 1000;

   typedef struct {
      logic                           action;
      logic signed [15:0]             degrees;
      logic [est_pkg::POWER_BITS-1:0] power;
      logic                           enc_l;
      logic                           enc_r;
   } turn_cmd_type;

   typedef struct packed {
      logic                           finished;
      logic                           turning;
      logic [est_pkg::DRIVE_BITS-1:0] right_drive;
      logic [est_pkg::DRIVE_BITS-1:0] left_drive;
   } drive_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [est_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [est_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [est_pkg::PPH_BITS-1:0] csr_wr_data = est_pkg::PPH_RESET;

   encoder_synchronized_spin_turn dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // turn state mirrored by the predictor
   logic [est_pkg::PPH_BITS-1:0]   half_turn_reg = est_pkg::PPH_RESET;
   logic [CNT_BITS-1:0]            goal_pulses = '0;
   logic [CNT_BITS-1:0]            left_pulses = '0;
   logic [CNT_BITS-1:0]            right_pulses = '0;
   logic                           last_lvl_l = 1'b0;
   logic                           last_lvl_r = 1'b0;
   logic                           spin_right = 1'b0;
   logic                           spinning = 1'b0;
   logic [est_pkg::POWER_BITS-1:0] spin_power = '0;

   turn_cmd_type   cmd_backlog[$];
   drive_beat_type drive_forecast[$];
   int unsigned items_queued = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   logic        req_beat_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned req_beats = 0;
   int unsigned rsp_cycles = 0;

   function automatic logic [est_pkg::DRIVE_BITS-1:0] signed_power(
         input logic [est_pkg::POWER_BITS-1:0] p, input logic neg);
      logic [est_pkg::DRIVE_BITS-1:0] d;
      d = {1'b0, p};
      return neg ? -d : d;
   endfunction

   function automatic drive_beat_type spin_turn_step(input turn_cmd_type c);
      drive_beat_type r;
      logic [16:0] mag;
      int unsigned goal;
      logic neg;
      r = '0;
      if (c.action == est_pkg::ACT_START) begin
         neg = c.degrees[15];
         mag = neg ? (17'h10000 - {1'b0, c.degrees}) : {1'b0, c.degrees};
         goal = 32'(mag) * 32'(half_turn_reg);
         goal = goal / est_pkg::DEG_PER_HALF_TURN;
         if (goal > 32'(CNT_MAX)) goal = 32'(CNT_MAX);
         goal_pulses = goal[CNT_BITS-1:0];
         left_pulses = '0;
         right_pulses = '0;
         last_lvl_l = c.enc_l;
         last_lvl_r = c.enc_r;
         spin_right = !neg && (c.degrees != 0);
         spin_power = c.power;
         if (goal == 0) begin
            spinning = 1'b0;
            r.finished = 1'b1;
         end else begin
            spinning = 1'b1;
            r.left_drive = signed_power(spin_power, !spin_right);
            r.right_drive = signed_power(spin_power, spin_right);
         end
      end else if (spinning) begin
         if (c.enc_l != last_lvl_l && left_pulses != CNT_MAX) left_pulses++;
         if (c.enc_r != last_lvl_r && right_pulses != CNT_MAX) right_pulses++;
         last_lvl_l = c.enc_l;
         last_lvl_r = c.enc_r;
         if (left_pulses >= goal_pulses && right_pulses >= goal_pulses) begin
            spinning = 1'b0;
            r.finished = 1'b1;
         end else begin
            if (!(left_pulses == goal_pulses || left_pulses > right_pulses))
               r.left_drive = signed_power(spin_power, !spin_right);
            if (!(right_pulses == goal_pulses || right_pulses > left_pulses))
               r.right_drive = signed_power(spin_power, spin_right);
         end
      end else begin
         last_lvl_l = c.enc_l;
         last_lvl_r = c.enc_r;
      end
      r.turning = spinning;
      return r;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(negedge clock) begin
      turn_cmd_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
            req_tdata <= $urandom;
            req_tuser <= 1'($urandom_range(0, 1));
         end else if (cmd_backlog.size() != 0) begin
            c = cmd_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= c.action;
            req_tdata <= {6'b0, c.enc_r, c.enc_l, c.power, c.degrees};
            req_beats++;
            gap_left = (req_beats[8:7] == 2'b11) ? 0 : idle_len();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_cycles++;
         if (rsp_cycles[8:7] != 2'b11 && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
   end

   // monitor: check result beats, then predict accepted request beats
   always @(posedge clock) begin
      drive_beat_type got, want;
      turn_cmd_type c;
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         req_beat_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got = rsp_tdata[19:0];
            if (drive_forecast.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: result beat %h with nothing expected", got);
            end else begin
               want = drive_forecast.pop_front();
               if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
                   got.turning !== want.turning || got.finished !== want.finished) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: result %0d: left %h/%h right %h/%h turning %b/%b fin %b/%b",
                              results_seen, got.left_drive, want.left_drive, got.right_drive,
                              want.right_drive, got.turning, want.turning, got.finished,
                              want.finished);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            c.action = req_tuser;
            c.degrees = req_tdata[15:0];
            c.power = req_tdata[23:16];
            c.enc_l = req_tdata[24];
            c.enc_r = req_tdata[25];
            drive_forecast.push_back(spin_turn_step(c));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else if (!reset && results_seen < items_queued)
         idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus
   logic enc_l = 1'b0;
   logic enc_r = 1'b0;

   task automatic push_item(input logic action, input int deg, input int power,
                            input logic l, input logic r);
      turn_cmd_type c;
      c.action = action;
      c.degrees = 16'(deg);
      c.power = 8'(power);
      c.enc_l = l;
      c.enc_r = r;
      enc_l = l;
      enc_r = r;
      cmd_backlog.push_back(c);
      items_queued++;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (results_seen < items_queued);
   endtask

   task automatic set_half_turn(input logic [est_pkg::PPH_BITS-1:0] v);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      half_turn_reg = v;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned first, n, pl, pr, goal_est;
      int deg, mag, r;
      first = items_queued;
      while (items_queued - first < count) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            mag = $urandom_range(0, 8) * 180 + $urandom_range(0, 179);
            if (half_turn_reg != 0) mag = mag / half_turn_reg;
            if (mag > 32767) mag = 32767;
            deg = $urandom_range(0, 1) ? -mag : mag;
         end else if (r < 90) begin
            deg = $urandom_range(0, 32767);
            if ($urandom_range(0, 1)) deg = -deg - 1;
         end else begin
            deg = $signed(16'($urandom));
         end
         mag = (deg < 0) ? -deg : deg;
         goal_est = mag * half_turn_reg / 180;
         push_item(est_pkg::ACT_START, deg, $urandom_range(0, 255),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         n = (goal_est > 20) ? $urandom_range(1, 15) : goal_est * 3 + $urandom_range(1, 4);
         pl = $urandom_range(50, 100);
         pr = $urandom_range(50, 100);
         repeat (n) begin
            if ($urandom_range(0, 99) < 4)
               push_item(1'($urandom_range(0, 1)), $signed(16'($urandom)),
                         $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            else
               push_item(est_pkg::ACT_SAMPLE, $signed(16'($urandom)), $urandom_range(0, 255),
                         enc_l ^ ($urandom_range(0, 99) < pl),
                         enc_r ^ ($urandom_range(0, 99) < pr));
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle samples, zero targets, start while busy, a short turn past its target
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, -1, 255, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, 0, 200, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, 1, 255, 1'b1, 1'b1);
      push_item(est_pkg::ACT_START, -1, 255, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, 8, 17, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, 90, 255, 1'b1, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b1);
      push_item(est_pkg::ACT_START, -32768, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, 32767, 128, 1'b0, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_START, -16, 255, 1'b0, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_START, 9, 1, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b0);
      run_random(240);

      set_half_turn(8'd1);
      run_random(240);

      set_half_turn(8'd255);
      push_item(est_pkg::ACT_START, 32767, 255, 1'b0, 1'b0);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b1, 1'b1);
      push_item(est_pkg::ACT_START, -32768, 1, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b1);
      run_random(240);

      set_half_turn(8'd0);
      push_item(est_pkg::ACT_START, 90, 100, 1'b0, 1'b0);
      push_item(est_pkg::ACT_START, -32768, 255, 1'b1, 1'b1);
      push_item(est_pkg::ACT_SAMPLE, 0, 0, 1'b0, 1'b0);
      run_random(100);

      set_half_turn(8'($urandom_range(2, 254)));
      run_random(200);
      set_half_turn(8'($urandom_range(2, 254)));
      run_random(200);

      set_half_turn(est_pkg::PPH_RESET);
      run_random(40);

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && drive_forecast.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
